// File: rtl/core/afpc_pkg.sv
// Shared constants, command codes and the step record of the ADC frame capture.
package afpc_pkg;

	// Pairs held in one bank of the two-bank store
	localparam int BANK_DEPTH = 256;
	localparam int IDX_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int ADDR_W     = IDX_W + 1;
	localparam int MEM_DEPTH  = 2 ** ADDR_W;

	// Frame layout: three status bytes, then 24-bit big-endian channels
	localparam int SAMPLE_W    = 24;
	localparam int PAIR_W      = 2 * SAMPLE_W;
	localparam int POS_W       = 5;
	localparam int FRAME_BYTES = 27;
	localparam int POS_IDLE    = FRAME_BYTES;
	localparam int CH1_FIRST   = 3;
	localparam int CH1_LAST    = 5;
	localparam int CH2_FIRST   = 6;
	localparam int CH2_LAST    = 8;
	localparam int COUNT_W     = 32;

	typedef enum logic [1:0] {
		CMD_BYTE   = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLAIM  = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	// What one accepted beat does to the store and reports
	typedef struct packed {
		logic                wr_en;
		logic [ADDR_W-1:0]   wr_addr;
		logic [PAIR_W-1:0]   wr_data;
		logic                rd_bank;
		logic                claim_ok;
		logic                bank_ready;
		logic                frame_stored;
		logic [COUNT_W-1:0]  samples_total;
	} step_t;

endpackage

// File: rtl/core/afpc_frame.sv
// Frame byte tracking, channel assembly, bank control and ready marks.
module afpc_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [1:0]           cmd,
	input  logic [7:0]           data_byte,
	input  logic                 frame_start,
	output afpc_pkg::step_t      step
);

	logic [afpc_pkg::POS_W-1:0]    byte_pos_q;
	logic [afpc_pkg::SAMPLE_W-1:0] first_q;
	logic [afpc_pkg::SAMPLE_W-1:0] second_q;
	logic                          wr_bank_q;
	logic [afpc_pkg::IDX_W-1:0]    wr_pos_q;
	logic [1:0]                    ready_q;
	logic [afpc_pkg::COUNT_W-1:0]  count_q;

	logic [afpc_pkg::POS_W-1:0]    pos;
	logic                          in_frame;
	logic                          take_byte;
	logic                          store;
	logic                          wrap;
	logic                          claim;
	logic                          wr_bank_d;
	logic [1:0]                    ready_d;
	logic [afpc_pkg::COUNT_W-1:0]  count_d;

	// Work out the effect of this beat
	always_comb begin
		pos       = frame_start ? '0 : byte_pos_q;
		in_frame  = pos < afpc_pkg::POS_W'(afpc_pkg::FRAME_BYTES);
		take_byte = en && (afpc_pkg::cmd_t'(cmd) == afpc_pkg::CMD_BYTE);
		store     = take_byte && (pos == afpc_pkg::POS_W'(afpc_pkg::FRAME_BYTES - 1));
		wrap      = wr_pos_q == afpc_pkg::IDX_W'(afpc_pkg::BANK_DEPTH - 1);
		claim     = en && (afpc_pkg::cmd_t'(cmd) == afpc_pkg::CMD_CLAIM)
			&& ready_q[~wr_bank_q];
		ready_d   = ready_q;
		wr_bank_d = wr_bank_q;
		if (store && wrap) begin
			ready_d[wr_bank_q]  = 1'b1;
			ready_d[~wr_bank_q] = 1'b0;
			wr_bank_d           = ~wr_bank_q;
		end
		if (claim) begin
			ready_d[~wr_bank_q] = 1'b0;
		end
		count_d = count_q + afpc_pkg::COUNT_W'(store);

		step.wr_en         = store;
		step.wr_addr       = {wr_bank_q, wr_pos_q};
		step.wr_data       = {first_q, second_q};
		step.rd_bank       = ~wr_bank_q;
		step.claim_ok      = claim;
		step.bank_ready    = ready_d[~wr_bank_d];
		step.frame_stored  = store;
		step.samples_total = count_d;
	end

	// Hold control state, advance on accepted beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			first_q    <= '0;
			second_q   <= '0;
			wr_bank_q  <= 1'b0;
			wr_pos_q   <= '0;
			ready_q    <= '0;
			count_q    <= '0;
		end else begin
			if (take_byte) begin
				if (in_frame) begin
					byte_pos_q <= pos + afpc_pkg::POS_W'(1);
					if (pos inside {[afpc_pkg::CH1_FIRST:afpc_pkg::CH1_LAST]}) begin
						first_q <= {first_q[afpc_pkg::SAMPLE_W-9:0], data_byte};
					end else if (pos inside {[afpc_pkg::CH2_FIRST:afpc_pkg::CH2_LAST]}) begin
						second_q <= {second_q[afpc_pkg::SAMPLE_W-9:0], data_byte};
					end
				end else begin
					byte_pos_q <= afpc_pkg::POS_W'(afpc_pkg::POS_IDLE);
				end
			end
			if (store) begin
				wr_pos_q <= wrap ? '0 : wr_pos_q + afpc_pkg::IDX_W'(1);
			end
			wr_bank_q <= wr_bank_d;
			ready_q   <= ready_d;
			count_q   <= count_d;
		end
	end

endmodule

// File: rtl/core/adc_frame_pingpong_capture.sv
// Ping-pong capture of ADC frames: takes one beat per clock cycle unless in_stall holds it,
// and presents its result beat through the sample store's registered read port, which
// loads on the accepting edge, and then the output register. The sample store is a
// 2 x BANK_DEPTH x 48-bit synchronous memory with one write port (frame completion
// into the write bank) and one read port (read command on the other bank); the two
// never address the same entry in the same cycle. The store needs no clearing pass: an
// entry never written reads as whatever it holds. Backpressure on the result side
// stalls the input only once both the read stage and the output register are full.
module adc_frame_pingpong_capture (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [7:0]                          data_byte,
	input  logic                                frame_start,
	input  logic [7:0]                          read_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [afpc_pkg::SAMPLE_W-1:0] sample_first,
	output logic signed [afpc_pkg::SAMPLE_W-1:0] sample_second,
	output logic                                claim_ok,
	output logic                                bank_ready,
	output logic                                frame_stored,
	output logic [afpc_pkg::COUNT_W-1:0]        samples_total
);

	afpc_pkg::step_t               step;
	logic                          acc_in;
	logic                          adv_s1;
	logic                          rd_en;
	logic [afpc_pkg::ADDR_W-1:0]   rd_addr;

	logic [afpc_pkg::PAIR_W-1:0]   mem [afpc_pkg::MEM_DEPTH];
	logic [afpc_pkg::PAIR_W-1:0]   rd_q;

	logic                          valid_s1;
	logic                          rd_s1;
	logic                          claim_s1;
	logic                          ready_s1;
	logic                          stored_s1;
	logic [afpc_pkg::COUNT_W-1:0]  total_s1;

	logic                          out_valid_q;
	logic [afpc_pkg::SAMPLE_W-1:0] first_q;
	logic [afpc_pkg::SAMPLE_W-1:0] second_q;
	logic                          claim_q;
	logic                          ready_q;
	logic                          stored_q;
	logic [afpc_pkg::COUNT_W-1:0]  total_q;

	// Handshake: the read stage moves on whenever the output register is free
	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign acc_in   = in_valid && !in_stall;

	afpc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (acc_in),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.step        (step)
	);

	// Read address in the bank not being written
	assign rd_en   = acc_in && (afpc_pkg::cmd_t'(cmd) == afpc_pkg::CMD_READ)
		&& (32'(read_index) < afpc_pkg::BANK_DEPTH);
	assign rd_addr = {step.rd_bank, afpc_pkg::IDX_W'(read_index)};

	// Sample store: write on frame completion, registered read
	always_ff @(posedge clk) begin
		if (step.wr_en) begin
			mem[step.wr_addr] <= step.wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Read stage: hold the status of the beat while the store answers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			rd_s1     <= rd_en;
			claim_s1  <= step.claim_ok;
			ready_s1  <= step.bank_ready;
			stored_s1 <= step.frame_stored;
			total_s1  <= step.samples_total;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			first_q  <= rd_s1 ? rd_q[afpc_pkg::PAIR_W-1:afpc_pkg::SAMPLE_W] : '0;
			second_q <= rd_s1 ? rd_q[afpc_pkg::SAMPLE_W-1:0] : '0;
			claim_q  <= claim_s1;
			ready_q  <= ready_s1;
			stored_q <= stored_s1;
			total_q  <= total_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_first  = $signed(first_q);
	assign sample_second = $signed(second_q);
	assign claim_ok      = claim_q;
	assign bank_ready    = ready_q;
	assign frame_stored  = stored_q;
	assign samples_total = total_q;

endmodule

// File: rtl/core/afpc_checker.sv
// Port-level checks for the ADC frame capture, bound to the top level.
module afpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [afpc_pkg::SAMPLE_W-1:0] sample_first,
	input logic signed [afpc_pkg::SAMPLE_W-1:0] sample_second,
	input logic                                claim_ok,
	input logic                                bank_ready,
	input logic                                frame_stored,
	input logic [afpc_pkg::COUNT_W-1:0]        samples_total
);

	// A stalled result beat holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(samples_total)
			&& $stable(claim_ok) && $stable(sample_first))
		else $error("result beat changed while stalled");

	// A successful claim leaves the read bank unmarked
	a_claim_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && claim_ok |-> !bank_ready)
		else $error("claim left the read bank marked ready");

	// A beat never reports both a granted claim and a stored frame
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(claim_ok && frame_stored))
		else $error("claim and frame store reported together");

	// Only a read command carries samples
	a_no_samples: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (claim_ok || frame_stored) |-> sample_first == 0 && sample_second == 0)
		else $error("samples reported on a non-read beat");

endmodule

bind adc_frame_pingpong_capture afpc_checker u_afpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.sample_first  (sample_first),
	.sample_second (sample_second),
	.claim_ok      (claim_ok),
	.bank_ready    (bank_ready),
	.frame_stored  (frame_stored),
	.samples_total (samples_total)
);

// File: test/tb.sv
// Self-checking testbench for the two-bank ADC frame capture block.
module tb;
	import afpc_pkg::*;

	localparam int     ITEM_TARGET  = 1950;
	localparam int     DRAIN_CYCLES = 16;
	localparam longint RUN_LIMIT    = 64'd200_000_000;

	// One result beat as the block reports it
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_first;
		logic signed [SAMPLE_W-1:0] sample_second;
		logic                       claim_ok;
		logic                       bank_ready;
		logic                       frame_stored;
		logic [COUNT_W-1:0]         samples_total;
	} capture_report_t;

	typedef enum logic {ROW_BEAT, ROW_FRAME} row_kind_e;

	// One line of the directed plan: a single beat, or a whole (possibly cut) frame
	typedef struct packed {
		row_kind_e           kind;
		cmd_t                op;
		logic [7:0]          data;
		logic                start;
		logic [7:0]          idx;
		logic [5:0]          length;
		logic [SAMPLE_W-1:0] ch_a;
		logic [SAMPLE_W-1:0] ch_b;
		logic [7:0]          fill;
		logic                typed;
		capture_report_t     want;
	} row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_STATUS;
	logic [7:0] data_byte = 8'h00;
	logic frame_start = 1'b0;
	logic [7:0] read_index = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_first;
	logic signed [SAMPLE_W-1:0] sample_second;
	logic claim_ok;
	logic bank_ready;
	logic frame_stored;
	logic [COUNT_W-1:0] samples_total;

	// Predictor state
	logic [POS_W-1:0]    frame_pos = '0;
	logic [SAMPLE_W-1:0] ch1_acc = '0;
	logic [SAMPLE_W-1:0] ch2_acc = '0;
	bit                  wr_bank = 1'b0;
	int                  wr_pos = 0;
	bit                  ready_mark [2] = '{1'b0, 1'b0};
	logic [SAMPLE_W-1:0] store_first [MEM_DEPTH];
	logic [SAMPLE_W-1:0] store_second [MEM_DEPTH];
	bit                  written [MEM_DEPTH];
	logic [COUNT_W-1:0]  pair_count = '0;

	// Run bookkeeping
	capture_report_t pending_reports [$];
	int fault_count = 0;
	int beats_sent = 0;
	int swap_count = 0;
	int reads_done = 0;
	int claims_granted = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	adc_frame_pingpong_capture dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.frame_start   (frame_start),
		.read_index    (read_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_first  (sample_first),
		.sample_second (sample_second),
		.claim_ok      (claim_ok),
		.bank_ready    (bank_ready),
		.frame_stored  (frame_stored),
		.samples_total (samples_total)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Advance the capture state by one accepted beat and return what it reports
	function automatic capture_report_t step_capture(cmd_t op, logic [7:0] data, logic start,
			logic [7:0] idx);
		capture_report_t r;
		int pos;
		int slot;
		r = '0;
		case (op)
			CMD_BYTE: begin
				pos = start ? 0 : int'(frame_pos);
				if (pos < FRAME_BYTES) begin
					if (pos >= CH1_FIRST && pos <= CH1_LAST)
						ch1_acc = {ch1_acc[SAMPLE_W-9:0], data};
					else if (pos >= CH2_FIRST && pos <= CH2_LAST)
						ch2_acc = {ch2_acc[SAMPLE_W-9:0], data};
					// last byte: store the pair, swap banks when the write bank fills
					if (pos == FRAME_BYTES - 1) begin
						slot = int'(wr_bank) * BANK_DEPTH + wr_pos;
						store_first[slot] = ch1_acc;
						store_second[slot] = ch2_acc;
						written[slot] = 1'b1;
						wr_pos++;
						pair_count++;
						if (wr_pos >= BANK_DEPTH) begin
							ready_mark[wr_bank] = 1'b1;
							wr_bank = ~wr_bank;
							wr_pos = 0;
							ready_mark[wr_bank] = 1'b0;
							swap_count++;
						end
						r.frame_stored = 1'b1;
					end
					frame_pos = POS_W'(pos + 1);
				end else begin
					frame_pos = POS_W'(POS_IDLE);
				end
			end
			CMD_READ: begin
				if (int'(idx) < BANK_DEPTH) begin
					slot = int'(!wr_bank) * BANK_DEPTH + int'(idx);
					r.sample_first = store_first[slot];
					r.sample_second = store_second[slot];
				end
				reads_done++;
			end
			CMD_CLAIM: begin
				if (ready_mark[~wr_bank]) begin
					r.claim_ok = 1'b1;
					ready_mark[~wr_bank] = 1'b0;
					claims_granted++;
				end
			end
			default: begin
			end
		endcase
		r.bank_ready = ready_mark[~wr_bank];
		r.samples_total = pair_count;
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long, none in a calm stretch
	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'hFFFFFF;
			3: return 24'h000000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic row_t beat_row(cmd_t op, logic [7:0] data, logic start, logic [7:0] idx,
			logic [COUNT_W-1:0] total);
		row_t r;
		r = '0;
		r.kind = ROW_BEAT;
		r.op = op;
		r.data = data;
		r.start = start;
		r.idx = idx;
		r.typed = 1'b1;
		r.want.samples_total = total;
		return r;
	endfunction

	function automatic row_t frame_row(logic start, int length, logic [SAMPLE_W-1:0] ch_a,
			logic [SAMPLE_W-1:0] ch_b, logic [7:0] fill);
		row_t r;
		r = '0;
		r.kind = ROW_FRAME;
		r.op = CMD_BYTE;
		r.start = start;
		r.length = 6'(length);
		r.ch_a = ch_a;
		r.ch_b = ch_b;
		r.fill = fill;
		return r;
	endfunction

	// Offer one beat, hold it until taken, then log what it should produce
	task automatic send_beat(input cmd_t op, input logic [7:0] data, input logic start,
			input logic [7:0] idx, input bit typed, input capture_report_t typed_want);
		int gap;
		capture_report_t predicted;
		if ($urandom_range(0, 299) == 0)
			tx_calm = ~tx_calm;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= op;
		data_byte <= data;
		frame_start <= start;
		read_index <= idx;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = step_capture(op, data, start, idx);
		pending_reports.push_back(typed ? typed_want : predicted);
		beats_sent++;
	endtask

	// Read, claim or status beat; reads only touch entries already written
	task automatic send_side_command();
		int roll;
		logic [7:0] idx;
		roll = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: idx = 8'h00;
			1: idx = 8'hFF;
			default: idx = 8'($urandom);
		endcase
		if (roll < 45 && written[int'(!wr_bank) * BANK_DEPTH + int'(idx)])
			send_beat(CMD_READ, 8'($urandom), 1'($urandom), idx, 1'b0, '0);
		else if (roll < 80 && swap_count != 1)
			send_beat(CMD_CLAIM, 8'($urandom), 1'($urandom), idx, 1'b0, '0);
		else
			send_beat(CMD_STATUS, 8'($urandom), 1'($urandom), idx, 1'b0, '0);
	endtask

	// Stream the bytes of one frame; a short length leaves it cut off
	task automatic send_frame(input logic first_start, input int length,
			input logic [SAMPLE_W-1:0] ch_a, input logic [SAMPLE_W-1:0] ch_b, input int fill,
			input bit mix);
		logic [7:0] b;
		for (int p = 0; p < length; p++) begin
			if (mix && p > 0 && $urandom_range(0, 99) < 8)
				send_side_command();
			if (p >= CH1_FIRST && p <= CH1_LAST)
				b = ch_a[8*(CH1_LAST-p) +: 8];
			else if (p >= CH2_FIRST && p <= CH2_LAST)
				b = ch_b[8*(CH2_LAST-p) +: 8];
			else if (fill < 0)
				b = 8'($urandom);
			else
				b = 8'(fill);
			send_beat(CMD_BYTE, b, (p == 0) ? first_start : 1'b0, 8'($urandom), 1'b0, '0);
		end
	endtask

	// Hold the sender off until every expected beat has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_report();
		capture_report_t want;
		if (pending_reports.size() == 0) begin
			$error("result beat with nothing expected");
			fault_count++;
		end else begin
			want = pending_reports.pop_front();
			if (sample_first !== want.sample_first) begin
				$error("sample_first: expected %0d, got %0d", want.sample_first, sample_first);
				fault_count++;
			end
			if (sample_second !== want.sample_second) begin
				$error("sample_second: expected %0d, got %0d", want.sample_second, sample_second);
				fault_count++;
			end
			if (claim_ok !== want.claim_ok) begin
				$error("claim_ok: expected %0d, got %0d", want.claim_ok, claim_ok);
				fault_count++;
			end
			if (bank_ready !== want.bank_ready) begin
				$error("bank_ready: expected %0d, got %0d", want.bank_ready, bank_ready);
				fault_count++;
			end
			if (frame_stored !== want.frame_stored) begin
				$error("frame_stored: expected %0d, got %0d", want.frame_stored, frame_stored);
				fault_count++;
			end
			if (samples_total !== want.samples_total) begin
				$error("samples_total: expected %0d, got %0d", want.samples_total, samples_total);
				fault_count++;
			end
		end
	endtask

	// Take result beats and stall the output at random
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				check_report();
			if ($urandom_range(0, 299) == 0)
				rx_calm = ~rx_calm;
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap(rx_calm);
			end
		end
	end

	initial begin : stimulus
		row_t plan [13];
		int roll;
		bit paused;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan: reset state, frame extremes, stray, cut and restarted frames
		plan = '{
			beat_row(CMD_STATUS, 8'hFF, 1'b1, 8'h00, 0),
			beat_row(CMD_CLAIM,  8'h00, 1'b0, 8'hFF, 0),
			frame_row(1'b0, FRAME_BYTES, 24'h7FFFFF, 24'h800000, 8'hFF),
			beat_row(CMD_BYTE,   8'h00, 1'b0, 8'hFF, 1),
			beat_row(CMD_BYTE,   8'hFF, 1'b0, 8'h00, 1),
			frame_row(1'b1, FRAME_BYTES, 24'h800000, 24'h7FFFFF, 8'h00),
			frame_row(1'b1, 9, 24'h123456, 24'h654321, 8'hA5),
			beat_row(CMD_STATUS, 8'h5A, 1'b0, 8'hA5, 2),
			frame_row(1'b1, FRAME_BYTES, 24'hFFFFFF, 24'h000000, 8'h5A),
			beat_row(CMD_CLAIM,  8'hFF, 1'b1, 8'h00, 3),
			frame_row(1'b1, 4, 24'hABCDEF, 24'h000000, 8'hC3),
			frame_row(1'b1, FRAME_BYTES, 24'h000001, 24'hFFFFFE, 8'hFF),
			beat_row(CMD_STATUS, 8'h00, 1'b1, 8'hFF, 4)
		};
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_BEAT)
				send_beat(plan[i].op, plan[i].data, plan[i].start, plan[i].idx,
					plan[i].typed, plan[i].want);
			else
				send_frame(plan[i].start, int'(plan[i].length), plan[i].ch_a, plan[i].ch_b,
					int'(plan[i].fill), 1'b0);
		end
		drain_results();

		// Random part: mostly whole frames, pause once half way to let the output drain
		while (beats_sent < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				send_frame(1'b1, FRAME_BYTES, pick_sample(), pick_sample(), -1, 1'b1);
			else if (roll < 76)
				send_frame(1'($urandom), $urandom_range(1, FRAME_BYTES - 1), pick_sample(),
					pick_sample(), -1, 1'b1);
			else if (roll < 80)
				send_beat(CMD_BYTE, 8'($urandom), 1'b0, 8'($urandom), 1'b0, '0);
			else
				send_side_command();
			if (!paused && beats_sent >= ITEM_TARGET / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d beats: %0d pairs stored, %0d bank swaps, %0d reads, %0d claims granted",
			beats_sent, pair_count, swap_count, reads_done, claims_granted);
		if (fault_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
